// ===== hw/rtl/sobel_pkg.sv =====
// Shared types and constants for the Sobel edge threshold block.
// Used by every module under hw/rtl; depends on nothing else.
package sobel_pkg;

	// Field widths of the pixel stream and the results.
	localparam int PIX_W        = 8;
	localparam int ROW_W        = 12;
	localparam int GRAD_W       = 11;

	// Configuration register widths, indexes and reset values.
	localparam int CFG_WIDTH_W  = 11;
	localparam int CFG_HEIGHT_W = 12;
	localparam int CFG_THR_W    = 11;
	localparam int CFG_DATA_W   = 12;
	localparam int CFG_IDX_W    = 2;

	localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH    = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT   = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_EDGE_THRESHOLD = 2'd2;

	localparam logic [CFG_WIDTH_W-1:0]  RST_IMAGE_WIDTH    = 11'd640;
	localparam logic [CFG_HEIGHT_W-1:0] RST_IMAGE_HEIGHT   = 12'd480;
	localparam logic [CFG_THR_W-1:0]    RST_EDGE_THRESHOLD = 11'd110;

	// Smallest legal frame size in either direction.
	localparam int MIN_DIM = 3;

	// Default line store depth.
	localparam int MAX_WIDTH_DEF = 1024;

	// Output pixel codes.
	localparam logic [PIX_W-1:0] PIX_EDGE  = 8'd0;
	localparam logic [PIX_W-1:0] PIX_BLANK = 8'd255;

	// Per-pixel flags produced by the position tracker.
	typedef struct packed {
		logic has_result;  // the pixel completes a window and emits a result
		logic border;      // the result pixel lies in the first row or column
		logic frame_done;  // the result is the last one of the frame
	} pos_info_t;

endpackage

// ===== hw/rtl/sobel_line_mem.sv =====
// One line store: a single-port-write, single-port-read memory of pixels.
// Read data is registered and read-before-write. Depends on sobel_pkg.
module sobel_line_mem
	import sobel_pkg::*;
#(
	parameter int Depth = MAX_WIDTH_DEF,
	parameter int AddrW = $clog2(MAX_WIDTH_DEF)
) (
	input  logic             clk,
	input  logic             rd_en,
	input  logic [AddrW-1:0] rd_addr,
	output logic [PIX_W-1:0] rd_data,
	input  logic             wr_en,
	input  logic [AddrW-1:0] wr_addr,
	input  logic [PIX_W-1:0] wr_data
);

	logic [PIX_W-1:0] mem [Depth];

	// Read and write share one clocked block; a read at the written address
	// returns the old contents.
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

endmodule

// ===== hw/rtl/sobel_position.sv =====
// Raster position tracker: places each accepted pixel at (row, column).
// Handles frame start, row and frame wrap, and size clamping. Uses sobel_pkg.
module sobel_position
	import sobel_pkg::*;
#(
	parameter int MaxWidth = MAX_WIDTH_DEF,
	parameter int AddrW    = $clog2(MAX_WIDTH_DEF)
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    advance,
	input  logic                    frame_start,
	input  logic [CFG_WIDTH_W-1:0]  image_width,
	input  logic [CFG_HEIGHT_W-1:0] image_height,
	output logic [ROW_W-1:0]        row,
	output logic [AddrW-1:0]        col,
	output pos_info_t               info
);

	localparam int CntW = $clog2(MaxWidth + 1);
	localparam int CmpW = (CntW > CFG_WIDTH_W) ? CntW : CFG_WIDTH_W;

	logic [ROW_W-1:0]        row_q;
	logic [CntW-1:0]         col_q;
	logic [CmpW-1:0]         width_ext;
	logic [CmpW-1:0]         eff_w;
	logic [CFG_HEIGHT_W-1:0] eff_h;
	logic                    wrap;
	logic [CntW-1:0]         col_full;
	logic [ROW_W-1:0]        row_pre;

	// Effective frame size: width clamped between the minimum and the line store, height to the minimum.
	always_comb begin
		width_ext = CmpW'(image_width);
		if (width_ext < CmpW'(MIN_DIM)) begin
			eff_w = CmpW'(MIN_DIM);
		end else if (width_ext > CmpW'(MaxWidth)) begin
			eff_w = CmpW'(MaxWidth);
		end else begin
			eff_w = width_ext;
		end
		eff_h = (image_height < CFG_HEIGHT_W'(MIN_DIM)) ? CFG_HEIGHT_W'(MIN_DIM)
			: image_height;
	end

	// Position of the pixel now offered: restart, wrap to the next row, wrap the frame.
	always_comb begin
		wrap = CmpW'(col_q) >= eff_w;
		if (frame_start) begin
			col_full = '0;
			row_pre  = '0;
		end else if (wrap) begin
			col_full = '0;
			row_pre  = row_q + ROW_W'(1);
		end else begin
			col_full = col_q;
			row_pre  = row_q;
		end
		row = (row_pre >= eff_h) ? '0 : row_pre;
		col = col_full[AddrW-1:0];
	end

	// Flags for the result that this pixel releases.
	always_comb begin
		info.has_result = (row != '0) && (col != '0);
		info.border     = (row == ROW_W'(1)) || (col == AddrW'(1));
		info.frame_done = (row == eff_h - CFG_HEIGHT_W'(1))
			&& (CmpW'(col) == eff_w - CmpW'(1));
	end

	// The counters point at the pixel that follows the accepted one.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q <= '0;
			col_q <= '0;
		end else if (advance) begin
			row_q <= row;
			col_q <= CntW'(col) + CntW'(1);
		end
	end

endmodule

// ===== hw/rtl/sobel_window.sv =====
// 3x3 window of the two previous columns plus the incoming column, and the
// Sobel gradient magnitude compare. Uses sobel_pkg.
module sobel_window
	import sobel_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 shift,
	input  logic [PIX_W-1:0]     top,
	input  logic [PIX_W-1:0]     mid,
	input  logic [PIX_W-1:0]     bot,
	input  logic [CFG_THR_W-1:0] threshold,
	output logic                 is_edge
);

	// Columns: index 0..2 is the oldest column (top, mid, bottom), 3..5 the next.
	logic [PIX_W-1:0] win_q [6];

	logic signed [GRAD_W-1:0] gx;
	logic signed [GRAD_W-1:0] gy;
	logic        [GRAD_W-1:0] abs_gx;
	logic        [GRAD_W-1:0] abs_gy;
	logic        [GRAD_W-1:0] mag;

	// Gradient of the window formed by the stored columns and the new one.
	// The center pixel carries no weight in either kernel.
	always_comb begin
		gx = (GRAD_W'(top) + (GRAD_W'(mid) << 1) + GRAD_W'(bot))
			- (GRAD_W'(win_q[0]) + (GRAD_W'(win_q[1]) << 1) + GRAD_W'(win_q[2]));
		gy = (GRAD_W'(win_q[2]) + (GRAD_W'(win_q[5]) << 1) + GRAD_W'(bot))
			- (GRAD_W'(win_q[0]) + (GRAD_W'(win_q[3]) << 1) + GRAD_W'(top));
		abs_gx  = gx[GRAD_W-1] ? GRAD_W'(-gx) : GRAD_W'(gx);
		abs_gy  = gy[GRAD_W-1] ? GRAD_W'(-gy) : GRAD_W'(gy);
		mag     = abs_gx + abs_gy;
		is_edge = mag > threshold;
	end

	// Shift the window by one column for every pixel that leaves the stage.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 6; i++) begin
				win_q[i] <= '0;
			end
		end else if (shift) begin
			win_q[0] <= win_q[3];
			win_q[1] <= win_q[4];
			win_q[2] <= win_q[5];
			win_q[3] <= top;
			win_q[4] <= mid;
			win_q[5] <= bot;
		end
	end

endmodule

// ===== hw/rtl/sobel_edge_threshold.sv =====
// Sobel edge detector with threshold: top level, pipeline and configuration.
// Instantiates sobel_position, sobel_line_mem and sobel_window; uses sobel_pkg.
//
// Takes one 8-bit gray pixel per clock in raster order and returns, for each
// pixel (r,c) with r>=1 and c>=1, the result for pixel (r-1,c-1): 0 when the
// Sobel magnitude |Gx|+|Gy| exceeds edge_threshold, 255 otherwise, and 255 for
// the first row and column. The last row and column are not emitted. The block
// sustains one pixel per clock while out_stall is low; the accepting edge does the
// registered read of the line stores into stage 1, and the edge on which stage 1
// moves on does the window arithmetic into the output register.
// The input stalls only while a result waits in the output register under
// out_stall. frame_start forces the position to (0,0); frames without it run
// back to back at the configured size.
// Width is clamped to 3..MAX_WIDTH and height to at least 3. The line stores
// are not cleared: growing the width mid-stream reads unwritten columns.
module sobel_edge_threshold
	import sobel_pkg::*;
#(
	parameter int MAX_WIDTH = MAX_WIDTH_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	// Configuration write port.
	input  logic                        cfg_we,
	input  logic [CFG_IDX_W-1:0]        cfg_index,
	input  logic [CFG_DATA_W-1:0]       cfg_wdata,
	// Pixel input channel.
	input  logic                        in_valid,
	output logic                        in_stall,
	input  logic [PIX_W-1:0]            pixel,
	input  logic                        frame_start,
	// Result output channel.
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic [PIX_W-1:0]            edge_value,
	output logic [ROW_W-1:0]            out_row,
	output logic [$clog2(MAX_WIDTH)-1:0] out_col,
	output logic                        frame_done
);

	localparam int AddrW = $clog2(MAX_WIDTH);

	// Configuration registers.
	logic [CFG_WIDTH_W-1:0]  width_q;
	logic [CFG_HEIGHT_W-1:0] height_q;
	logic [CFG_THR_W-1:0]    thr_q;

	// Handshake and position of the offered pixel.
	logic             accept;
	logic             s1_adv;
	logic [ROW_W-1:0] row_new;
	logic [AddrW-1:0] col_new;
	pos_info_t        info_new;
	logic             hit;

	// Stage 1: pixel waiting for its line store data.
	logic             valid_s1;
	logic [PIX_W-1:0] pix_s1;
	logic [ROW_W-1:0] row_s1;
	logic [AddrW-1:0] col_s1;
	pos_info_t        info_s1;
	logic             byp_s1;
	logic [PIX_W-1:0] byp_top_s1;
	logic [PIX_W-1:0] byp_mid_s1;
	logic [PIX_W-1:0] upper_rd;
	logic [PIX_W-1:0] middle_rd;
	logic [PIX_W-1:0] top_s1;
	logic [PIX_W-1:0] mid_s1;
	logic             is_edge;

	// Stage 2: output register.
	logic             valid_s2;
	logic [PIX_W-1:0] value_s2;
	logic [ROW_W-1:0] row_s2;
	logic [AddrW-1:0] col_s2;
	logic             done_s2;

	// Configuration writes; indexes beyond the list are ignored.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= RST_IMAGE_WIDTH;
			height_q <= RST_IMAGE_HEIGHT;
			thr_q    <= RST_EDGE_THRESHOLD;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_IMAGE_WIDTH:    width_q  <= cfg_wdata[CFG_WIDTH_W-1:0];
				REG_IMAGE_HEIGHT:   height_q <= cfg_wdata[CFG_HEIGHT_W-1:0];
				REG_EDGE_THRESHOLD: thr_q    <= cfg_wdata[CFG_THR_W-1:0];
				default: ;
			endcase
		end
	end

	// Stage 1 moves on when the output register is free or will be emptied.
	assign s1_adv   = valid_s1 && (!valid_s2 || !out_stall);
	assign in_stall = valid_s1 && !s1_adv;
	assign accept   = in_valid && !in_stall;

	sobel_position #(
		.MaxWidth (MAX_WIDTH),
		.AddrW    (AddrW)
	) u_position (
		.clk          (clk),
		.arst_n       (arst_n),
		.advance      (accept),
		.frame_start  (frame_start),
		.image_width  (width_q),
		.image_height (height_q),
		.row          (row_new),
		.col          (col_new),
		.info         (info_new)
	);

	// Line stores: read at accept, written back when the pixel leaves stage 1.
	sobel_line_mem #(
		.Depth (MAX_WIDTH),
		.AddrW (AddrW)
	) u_upper (
		.clk     (clk),
		.rd_en   (accept),
		.rd_addr (col_new),
		.rd_data (upper_rd),
		.wr_en   (s1_adv),
		.wr_addr (col_s1),
		.wr_data (mid_s1)
	);

	sobel_line_mem #(
		.Depth (MAX_WIDTH),
		.AddrW (AddrW)
	) u_middle (
		.clk     (clk),
		.rd_en   (accept),
		.rd_addr (col_new),
		.rd_data (middle_rd),
		.wr_en   (s1_adv),
		.wr_addr (col_s1),
		.wr_data (pix_s1)
	);

	// A read that meets the write of the same column in one edge sees old data;
	// the written values are forwarded instead.
	assign hit = s1_adv && (col_s1 == col_new);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (s1_adv) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			pix_s1     <= pixel;
			row_s1     <= row_new;
			col_s1     <= col_new;
			info_s1    <= info_new;
			byp_s1     <= hit;
			byp_top_s1 <= mid_s1;
			byp_mid_s1 <= pix_s1;
		end
	end

	assign top_s1 = byp_s1 ? byp_top_s1 : upper_rd;
	assign mid_s1 = byp_s1 ? byp_mid_s1 : middle_rd;

	sobel_window u_window (
		.clk       (clk),
		.arst_n    (arst_n),
		.shift     (s1_adv),
		.top       (top_s1),
		.mid       (mid_s1),
		.bot       (pix_s1),
		.threshold (thr_q),
		.is_edge   (is_edge)
	);

	// Output register: loaded only by pixels that release a result.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (s1_adv && info_s1.has_result) begin
			valid_s2 <= 1'b1;
		end else if (valid_s2 && !out_stall) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_adv && info_s1.has_result) begin
			value_s2 <= (info_s1.border || !is_edge) ? PIX_BLANK : PIX_EDGE;
			row_s2   <= row_s1 - ROW_W'(1);
			col_s2   <= col_s1 - AddrW'(1);
			done_s2  <= info_s1.frame_done;
		end
	end

	assign out_valid  = valid_s2;
	assign edge_value = value_s2;
	assign out_row    = row_s2;
	assign out_col    = col_s2;
	assign frame_done = done_s2;

	// Only the two pixel codes are ever produced.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (edge_value == PIX_EDGE || edge_value == PIX_BLANK))
		else $error("result is neither edge nor blank");

	// The first row and column of a frame are always blank.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (out_row == '0 || out_col == '0) |-> edge_value == PIX_BLANK)
		else $error("border result marked as edge");

	// A pixel that releases a result lands in the output register.
	assert property (@(posedge clk) disable iff (!arst_n)
		s1_adv && info_s1.has_result |=> out_valid)
		else $error("released result was lost");

	// The input is held back only while stage 1 and the output register are occupied under out_stall.
	assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> valid_s1 && valid_s2 && out_stall)
		else $error("input stalled without a blocked pipeline");

endmodule
